>>> hw/rtl/work_stealing_deque_core_macros.svh
// Assertion macros for the work-stealing deque checker.
// Used by wsd_checker.sv; expects clk and rst_n in scope.
`ifndef WORK_STEALING_DEQUE_CORE_MACROS_SVH
`define WORK_STEALING_DEQUE_CORE_MACROS_SVH

// Clocked assertion, ignored while reset is asserted
`define WSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: antecedent then consequent in the same cycle
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/wsd_pkg.sv
// Shared types and constants for the work-stealing deque.
// No dependencies.
package wsd_pkg;

    // Ring size; must be a power of two
    localparam int DEPTH   = 64;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int PTR_W   = SLOT_W + 1;
    localparam int COUNT_W = 7;
    localparam int JOB_W   = 32;
    localparam int TASK_W  = 16;
    localparam int ITEM_W  = JOB_W + TASK_W;

    // Request codes
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_STEAL = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming request
        logic exec;     // update pointers, access the slot memory
        logic load;     // load the output register
    } wsd_ctl_t;

endpackage

>>> hw/rtl/wsd_req_if.sv
// Request channel interface: valid/ready plus request payload.
// Depends on wsd_pkg.
interface wsd_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  cmd;
    logic [wsd_pkg::JOB_W-1:0]   job_ref;
    logic [wsd_pkg::TASK_W-1:0]  task_id;

    modport source (output valid, cmd, job_ref, task_id, input ready);
    modport sink   (input valid, cmd, job_ref, task_id, output ready);
endinterface

>>> hw/rtl/wsd_rsp_if.sv
// Result channel interface: valid/ready plus result payload.
// Depends on wsd_pkg.
interface wsd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [wsd_pkg::JOB_W-1:0]    out_job_ref;
    logic [wsd_pkg::TASK_W-1:0]   out_task_id;
    logic [wsd_pkg::COUNT_W-1:0]  queue_count;

    modport source (output valid, status, out_job_ref, out_task_id, queue_count,
                    input ready);
    modport sink   (input valid, status, out_job_ref, out_task_id, queue_count,
                    output ready);
endinterface

>>> hw/rtl/wsd_ctrl.sv
// Sequencing controller for the work-stealing deque.
// Depends on wsd_pkg; drives wsd_datapath through a wsd_ctl_t command struct.
module wsd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output wsd_pkg::wsd_ctl_t ctl
);

    wsd_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_full_reg, out_full_next;
    logic                 can_load;

    // State and output-occupancy registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wsd_pkg::ST_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    // Output register is free, or drains this cycle
    assign can_load = !out_full_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            wsd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = wsd_pkg::ST_EXEC;
                end
            end
            wsd_pkg::ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = wsd_pkg::ST_LOAD;
            end
            wsd_pkg::ST_LOAD:
            begin
                if (can_load)
                begin
                    ctl.load   = 1'b1;
                    state_next = wsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wsd_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid tracking
    always_comb
    begin
        if (ctl.load)
            out_full_next = 1'b1;
        else if (out_ready)
            out_full_next = 1'b0;
        else
            out_full_next = out_full_reg;
    end

    assign out_valid = out_full_reg;

endmodule

>>> hw/rtl/wsd_datapath.sv
// Datapath of the work-stealing deque: pointers, slot memory, output register.
// Depends on wsd_pkg; sequenced by wsd_ctrl.
module wsd_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wsd_pkg::wsd_ctl_t            ctl,
    input  logic [1:0]                   cmd,
    input  logic [wsd_pkg::JOB_W-1:0]    job_ref,
    input  logic [wsd_pkg::TASK_W-1:0]   task_id,
    output logic [1:0]                   status,
    output logic [wsd_pkg::JOB_W-1:0]    out_job_ref,
    output logic [wsd_pkg::TASK_W-1:0]   out_task_id,
    output logic [wsd_pkg::COUNT_W-1:0]  queue_count
);

    localparam logic [wsd_pkg::PTR_W-1:0] PTR_ONE  = wsd_pkg::PTR_W'(1);
    localparam logic [wsd_pkg::PTR_W-1:0] PTR_FULL = wsd_pkg::PTR_W'(wsd_pkg::DEPTH);

    // Slot memory
    logic [wsd_pkg::ITEM_W-1:0] slot_mem [wsd_pkg::DEPTH];

    // Captured request
    logic [1:0]                  cmd_reg;
    logic [wsd_pkg::JOB_W-1:0]   job_reg;
    logic [wsd_pkg::TASK_W-1:0]  task_reg;

    // Deque pointers, modulo 2*DEPTH
    logic [wsd_pkg::PTR_W-1:0]   bottom_reg, bottom_next;
    logic [wsd_pkg::PTR_W-1:0]   top_reg, top_next;

    // Execute results
    wsd_pkg::status_t            status_reg, status_next;
    logic                        has_item_reg, has_item_next;
    logic [wsd_pkg::PTR_W-1:0]   count_reg;
    logic [wsd_pkg::ITEM_W-1:0]  rd_data_reg;

    // Output register
    logic [1:0]                   out_status_reg;
    logic [wsd_pkg::JOB_W-1:0]    out_job_reg;
    logic [wsd_pkg::TASK_W-1:0]   out_task_reg;
    logic [wsd_pkg::COUNT_W-1:0]  out_count_reg;

    logic [wsd_pkg::PTR_W-1:0]   held;
    logic [wsd_pkg::PTR_W-1:0]   bottom_dec;
    logic                        mem_we, mem_re;
    logic [wsd_pkg::SLOT_W-1:0]  mem_addr;

    assign held       = bottom_reg - top_reg;
    assign bottom_dec = bottom_reg - PTR_ONE;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= cmd;
            job_reg  <= job_ref;
            task_reg <= task_id;
        end
    end

    // Execute decode: pointer updates and memory access
    always_comb
    begin
        bottom_next   = bottom_reg;
        top_next      = top_reg;
        status_next   = wsd_pkg::STAT_OK;
        has_item_next = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = bottom_reg[wsd_pkg::SLOT_W-1:0];
        case (cmd_reg)
            wsd_pkg::CMD_PUSH:
            begin
                if (held == PTR_FULL)
                    status_next = wsd_pkg::STAT_FULL;
                else
                begin
                    mem_we      = ctl.exec;
                    bottom_next = bottom_reg + PTR_ONE;
                end
            end
            wsd_pkg::CMD_POP:
            begin
                mem_addr = bottom_dec[wsd_pkg::SLOT_W-1:0];
                if (held == '0)
                    status_next = wsd_pkg::STAT_EMPTY;
                else
                begin
                    mem_re        = ctl.exec;
                    has_item_next = 1'b1;
                    // last item leaves through the top pointer
                    if (held == PTR_ONE)
                        top_next = top_reg + PTR_ONE;
                    else
                        bottom_next = bottom_dec;
                end
            end
            wsd_pkg::CMD_STEAL:
            begin
                mem_addr = top_reg[wsd_pkg::SLOT_W-1:0];
                if (held == '0)
                    status_next = wsd_pkg::STAT_EMPTY;
                else
                begin
                    mem_re        = ctl.exec;
                    has_item_next = 1'b1;
                    top_next      = top_reg + PTR_ONE;
                end
            end
            default:
            begin
                // unused code: no change
            end
        endcase
    end

    // Pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_reg <= '0;
            top_reg    <= '0;
        end
        else if (ctl.exec)
        begin
            bottom_reg <= bottom_next;
            top_reg    <= top_next;
        end
    end

    // Slot memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_addr] <= {job_reg, task_reg};
        if (mem_re)
            rd_data_reg <= slot_mem[mem_addr];
    end

    // Execute result registers
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            status_reg   <= status_next;
            has_item_reg <= has_item_next;
            count_reg    <= bottom_next - top_next;
        end
    end

    // Output register load
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= wsd_pkg::COUNT_W'(count_reg);
            if (has_item_reg)
            begin
                out_job_reg  <= rd_data_reg[wsd_pkg::ITEM_W-1:wsd_pkg::TASK_W];
                out_task_reg <= rd_data_reg[wsd_pkg::TASK_W-1:0];
            end
            else
            begin
                out_job_reg  <= '0;
                out_task_reg <= '0;
            end
        end
    end

    assign status      = out_status_reg;
    assign out_job_ref = out_job_reg;
    assign out_task_id = out_task_reg;
    assign queue_count = out_count_reg;

endmodule

>>> hw/rtl/work_stealing_deque_core.sv
// Work-stealing deque core: a ring of 64 slots with one request channel and one
// result channel. The owner pushes and pops at the bottom, thieves steal from the
// top; every request yields exactly one result with a status (ok, empty, full),
// the popped or stolen item (zero otherwise) and the item count after the
// request. A request runs in three steps: capture, execute (pointer update plus
// one access to the single-port slot memory) and load of the output register.
// The controller runs one request at a time: a new request is taken once the
// previous one has loaded the output register; a request may be accepted while
// the previous result still waits, and a stalled result holds the load step.
// Slot contents are undefined after reset, and no clearing pass is needed.
// Depends on wsd_pkg, wsd_req_if, wsd_rsp_if, wsd_ctrl and wsd_datapath.
module work_stealing_deque_core (
    input  logic      clk,
    input  logic      rst_n,
    wsd_req_if.sink   req,
    wsd_rsp_if.source rsp
);

    wsd_pkg::wsd_ctl_t ctl;

    // Sequencer
    wsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    // Pointers, slots and result register
    wsd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cmd         (req.cmd),
        .job_ref     (req.job_ref),
        .task_id     (req.task_id),
        .status      (rsp.status),
        .out_job_ref (rsp.out_job_ref),
        .out_task_id (rsp.out_task_id),
        .queue_count (rsp.queue_count)
    );

endmodule

>>> hw/rtl/wsd_checker.sv
// Port-level checker for work_stealing_deque_core, attached with bind.
// Depends on wsd_pkg and work_stealing_deque_core_macros.svh.
`include "work_stealing_deque_core_macros.svh"

module wsd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [1:0]                   status,
    input logic [wsd_pkg::JOB_W-1:0]    out_job_ref,
    input logic [wsd_pkg::TASK_W-1:0]   out_task_id,
    input logic [wsd_pkg::COUNT_W-1:0]  queue_count
);

    localparam logic [wsd_pkg::COUNT_W-1:0] CNT_MAX = wsd_pkg::COUNT_W'(wsd_pkg::DEPTH);

    // A stalled result holds
    `WSD_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(out_job_ref) && $stable(out_task_id) && $stable(queue_count)), "stalled result changed")

    // Empty result carries no item and a zero count
    `WSD_ASSERT_IMP(a_empty_zero, rsp_valid && status == wsd_pkg::STAT_EMPTY, out_job_ref == '0 && out_task_id == '0 && queue_count == '0, "empty result not clean")

    // Full result carries no item and a full count
    `WSD_ASSERT_IMP(a_full_count, rsp_valid && status == wsd_pkg::STAT_FULL, out_job_ref == '0 && out_task_id == '0 && queue_count == CNT_MAX, "full result inconsistent")

    // Count never exceeds the ring size
    `WSD_ASSERT_IMP(a_count_range, rsp_valid, queue_count <= CNT_MAX, "count out of range")

endmodule

bind work_stealing_deque_core wsd_checker u_wsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .out_job_ref (rsp.out_job_ref),
    .out_task_id (rsp.out_task_id),
    .queue_count (rsp.queue_count)
);
